// ----- rtl/core/trap_pkg.sv -----
// ----------------------------------------------------------------------------
// trap_pkg
// Shared types and constants for the trapezoid-rule integrator.
// ----------------------------------------------------------------------------
package trap_pkg;

    localparam int unsigned BOUND_W = 24;
    localparam int unsigned CNT_IN_W = 20;
    localparam int unsigned AREA_W = 32;
    localparam int unsigned F_W = 32;
    localparam int unsigned MAG_W = 23;

    localparam logic [MAG_W-1:0] MAG_LIMIT = '1;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // sideband that rides with each point through the evaluator
    typedef struct packed {
        logic last;
        logic end_pt;
    } t_pt_tag;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_EVAL   = 6'b000100,
        S_ASTART = 6'b001000,
        S_AWAIT  = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

endpackage

// ----- rtl/core/trap_hdiv.sv -----
// ----------------------------------------------------------------------------
// trap_hdiv
// Bit-serial restoring divider for the step size, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module trap_hdiv #(
    parameter int unsigned DW = 40,
    parameter int unsigned NW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_rem;
    logic [DW-1:0] r_quot;
    logic [NW-1:0] r_div;

    logic [NW:0] trial;
    logic        ge;
    logic [NW:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quot[DW-1]};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? (trial - {1'b0, r_div}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem[NW-1:0];
            r_quot <= {r_quot[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/core/trap_eval.sv -----
// ----------------------------------------------------------------------------
// trap_eval
// Pipelined evaluator of f(x) = sqrt((1 + x^2) / (1 + x^4)), Q.30 result.
// One point a cycle; 68 stages: squares, 31 divide stages, then the root stages.
// ----------------------------------------------------------------------------
module trap_eval import trap_pkg::*; #(
    parameter int unsigned PW = 41
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [PW-1:0] i_point,
    input  t_pt_tag              i_tag,
    output logic                 o_valid,
    output t_pt_tag              o_tag,
    output logic [F_W-1:0]       o_f
);

    localparam int unsigned DIV_STEPS = 30;
    localparam int unsigned SQ_STEPS = 32;

    // magnitude, truncated to Q.16 and clamped
    logic [PW-1:0]    ux;
    logic [PW+23:0]   uxw;
    logic [MAG_W-1:0] m;

    always_comb begin
        ux  = i_point[PW-1] ? unsigned'(~i_point + 1'b1) : unsigned'(i_point);
        uxw = {24'b0, ux};
        m   = (|uxw[PW+23:39]) ? MAG_LIMIT : uxw[38:16];
    end

    logic             r_v1, r_v2, r_v3, r_v4;
    t_pt_tag          r_t1, r_t2, r_t3, r_t4;
    logic [MAG_W-1:0] r_m1;
    logic [45:0]      r_x2_2, r_x2_3;
    logic [59:0]      r_x4_3;
    logic [46:0]      r_num4;
    logic [60:0]      r_den4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1   <= i_tag;
        r_m1   <= m;
        r_t2   <= r_t1;
        r_x2_2 <= r_m1 * r_m1;
        r_t3   <= r_t2;
        r_x2_3 <= r_x2_2;
        r_x4_3 <= r_x2_2[45:16] * r_x2_2[45:16];
        r_t4   <= r_t3;
        r_num4 <= 47'(ONE_Q32) + 47'(r_x2_3);
        r_den4 <= 61'(ONE_Q32) + 61'(r_x4_3);
    end

    // divide stages: index 0 holds the integer quotient bit
    logic        dv_v   [0:DIV_STEPS];
    t_pt_tag     dv_t   [0:DIV_STEPS];
    logic [60:0] dv_rem [0:DIV_STEPS];
    logic [60:0] dv_den [0:DIV_STEPS];
    logic [30:0] dv_q   [0:DIV_STEPS];

    logic [60:0] num_w;
    logic        q0;

    always_comb begin
        num_w = 61'(r_num4);
        q0    = num_w >= r_den4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_v[0] <= 1'b0;
        end else begin
            dv_v[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        dv_t[0]   <= r_t4;
        dv_rem[0] <= q0 ? (num_w - r_den4) : num_w;
        dv_den[0] <= r_den4;
        dv_q[0]   <= {30'b0, q0};
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [61:0] rem2;
        logic        ge;
        logic [61:0] nrem;

        always_comb begin
            rem2 = {dv_rem[k], 1'b0};
            ge   = rem2 >= {1'b0, dv_den[k]};
            nrem = ge ? (rem2 - {1'b0, dv_den[k]}) : rem2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_v[k+1] <= 1'b0;
            end else begin
                dv_v[k+1] <= dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            dv_t[k+1]   <= dv_t[k];
            dv_rem[k+1] <= nrem[60:0];
            dv_den[k+1] <= dv_den[k];
            dv_q[k+1]   <= {dv_q[k][29:0], ge};
        end
    end

    // bit-serial square root of q << 30
    logic        sq_v    [0:SQ_STEPS];
    t_pt_tag     sq_t    [0:SQ_STEPS];
    logic [63:0] sq_rem  [0:SQ_STEPS];
    logic [63:0] sq_root [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            sq_v[0] <= 1'b0;
        end else begin
            sq_v[0] <= dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        sq_t[0]    <= dv_t[DIV_STEPS];
        sq_rem[0]  <= {3'b0, dv_q[DIV_STEPS], 30'b0};
        sq_root[0] <= '0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        logic        ge;

        always_comb begin
            trial = sq_root[k] + BIT;
            ge    = sq_rem[k] >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                sq_v[k+1] <= 1'b0;
            end else begin
                sq_v[k+1] <= sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            sq_t[k+1]    <= sq_t[k];
            sq_rem[k+1]  <= ge ? (sq_rem[k] - trial) : sq_rem[k];
            sq_root[k+1] <= ge ? ((sq_root[k] >> 1) + BIT) : (sq_root[k] >> 1);
        end
    end

    assign o_valid = sq_v[SQ_STEPS];
    assign o_tag   = sq_t[SQ_STEPS];
    assign o_f     = sq_root[SQ_STEPS][F_W-1:0];

endmodule

// ----- rtl/core/trap_area.sv -----
// ----------------------------------------------------------------------------
// trap_area
// Multiplies |h| by the weighted sum in 27-bit chunks, one partial product a
// cycle, then scales and saturates to the signed Q16.16 area.
// ----------------------------------------------------------------------------
module trap_area import trap_pkg::*; #(
    parameter int unsigned DW  = 40,
    parameter int unsigned SW  = 53,
    parameter int unsigned SHR = 47
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DW-1:0]     i_hmag,
    input  logic              i_neg,
    input  logic [SW-1:0]     i_sum,
    output logic              o_done,
    output logic [AREA_W-1:0] o_area
);

    localparam int unsigned K    = 27;
    localparam int unsigned HC   = (DW + K - 1) / K;
    localparam int unsigned SC   = (SW + K - 1) / K;
    localparam int unsigned HPW  = HC * K;
    localparam int unsigned SPW  = SC * K;
    localparam int unsigned ACCW = HPW + SPW;
    localparam int unsigned HCW  = (HC > 1) ? $clog2(HC) : 1;
    localparam int unsigned SCW  = (SC > 1) ? $clog2(SC) : 1;
    localparam int unsigned OFFW = $clog2(ACCW);
    localparam int unsigned SHW  = ((ACCW - SHR) > 33) ? (ACCW - SHR) : 33;

    logic [HPW-1:0]    r_h;
    logic [SPW-1:0]    r_s;
    logic              r_neg;
    logic              r_run;
    logic [HCW-1:0]    r_hc;
    logic [SCW-1:0]    r_sc;
    logic [2*K-1:0]    r_pp;
    logic [OFFW-1:0]   r_off;
    logic              r_ppv;
    logic              r_pplast;
    logic [ACCW-1:0]   r_acc;
    logic              r_fin;
    logic              r_done;
    logic [AREA_W-1:0] r_area;

    logic [K-1:0]      hchunk;
    logic [K-1:0]      schunk;
    logic              sc_wrap;
    logic              last_pair;
    logic [SHW-1:0]    shifted;
    logic              pos_big;
    logic              neg_big;
    logic [31:0]       nmag;

    always_comb begin
        hchunk    = r_h[r_hc*K +: K];
        schunk    = r_s[r_sc*K +: K];
        sc_wrap   = r_sc == SCW'(SC - 1);
        last_pair = (r_hc == HCW'(HC - 1)) && sc_wrap;
        shifted   = SHW'(r_acc >> SHR);
        pos_big   = |shifted[SHW-1:31];
        neg_big   = (|shifted[SHW-1:32]) || (shifted[31] && (|shifted[30:0]));
        nmag      = neg_big ? 32'h8000_0000 : shifted[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_ppv    <= 1'b0;
            r_pplast <= 1'b0;
            r_fin    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= r_fin;
            r_ppv    <= r_run;
            r_pplast <= r_run && last_pair;
            r_fin    <= r_ppv && r_pplast;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && last_pair) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h   <= HPW'(i_hmag);
            r_s   <= SPW'(i_sum);
            r_neg <= i_neg;
            r_hc  <= '0;
            r_sc  <= '0;
            r_acc <= '0;
        end else begin
            if (r_run) begin
                r_pp  <= hchunk * schunk;
                r_off <= OFFW'((r_hc + r_sc) * K);
                if (sc_wrap) begin
                    r_sc <= '0;
                    r_hc <= r_hc + 1'b1;
                end else begin
                    r_sc <= r_sc + 1'b1;
                end
            end
            if (r_ppv) begin
                r_acc <= r_acc + (ACCW'(r_pp) << r_off);
            end
        end
        if (r_fin) begin
            if (r_neg) begin
                r_area <= ~nmag + 1'b1;
            end else begin
                r_area <= pos_big ? 32'h7FFF_FFFF : shifted[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_area = r_area;

endmodule

// ----- rtl/core/trapezoid_rule_integrator.sv -----
// Sequence for n subintervals: serial step divide, n + 1 points issued one a
//   cycle into a 68-stage evaluator, then a chunked multiply and the output
//   hand-off.
// Throughput: one item at a time; the next beat is taken once the result sits in
//   the output register. n = 0 skips the divide and returns zero.
// Reset: synchronous, active low; clears the control state and all valid bits.
// ----------------------------------------------------------------------------
// trapezoid_rule_integrator
// Trapezoid-rule area of sqrt((1 + x^2) / (1 + x^4)) between two Q8.16 bounds.
// ----------------------------------------------------------------------------
module trapezoid_rule_integrator import trap_pkg::*; #(
    parameter int unsigned COUNT_BITS = 20,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [BOUND_W-1:0]  i_lower_bound,
    input  logic signed [BOUND_W-1:0]  i_upper_bound,
    input  logic [CNT_IN_W-1:0]        i_subintervals,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [AREA_W-1:0]   o_area
);

    localparam int unsigned NW = (COUNT_BITS < CNT_IN_W) ? COUNT_BITS : CNT_IN_W;
    localparam int unsigned SC = 32 - FRAC_BITS;
    localparam int unsigned DW = 56 - FRAC_BITS;
    localparam int unsigned PW = DW + 1;
    localparam int unsigned SW = 33 + NW;
    localparam int unsigned SHR = 63 - FRAC_BITS;

    t_state                r_state;
    logic [NW-1:0]         r_n;
    logic [NW:0]           r_icnt;
    logic signed [PW-1:0]  r_point;
    logic signed [PW-1:0]  r_step;
    logic [DW-1:0]         r_hmag;
    logic                  r_hneg;
    logic [SW-1:0]         r_sum;
    logic [AREA_W-1:0]     r_res;
    logic                  r_out_valid;
    logic [AREA_W-1:0]     r_area_out;

    logic                  accept;
    logic [NW-1:0]         n_in;
    logic signed [PW-1:0]  a_ext;
    logic signed [PW-1:0]  b_ext;
    logic signed [PW-1:0]  diff;
    logic [PW-1:0]         diff_abs;
    logic                  div_done;
    logic [DW-1:0]         quot;
    logic                  issue;
    t_pt_tag               tag_in;
    logic                  ev_valid;
    t_pt_tag               ev_tag;
    logic [F_W-1:0]        ev_f;
    logic [SW-1:0]         addend;
    logic                  area_done;
    logic [AREA_W-1:0]     area_val;
    logic                  out_free;

    always_comb begin
        accept   = i_valid && (r_state == S_IDLE);
        n_in     = i_subintervals[NW-1:0];
        a_ext    = PW'(i_lower_bound);
        b_ext    = PW'(i_upper_bound);
        diff     = (b_ext - a_ext) <<< SC;
        diff_abs = diff[PW-1] ? unsigned'(-diff) : unsigned'(diff);
        issue    = (r_state == S_EVAL) && (r_icnt <= {1'b0, r_n});
        tag_in.last   = r_icnt == {1'b0, r_n};
        tag_in.end_pt = (r_icnt == '0) || (r_icnt == {1'b0, r_n});
        addend   = ev_tag.end_pt ? SW'(ev_f) : SW'({ev_f, 1'b0});
        out_free = !r_out_valid || !i_stall;
    end

    trap_hdiv #(
        .DW (DW),
        .NW (NW)
    ) u_hdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && (n_in != '0)),
        .i_dividend (diff_abs[DW-1:0]),
        .i_divisor  (n_in),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    trap_eval #(
        .PW (PW)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_point (r_point),
        .i_tag   (tag_in),
        .o_valid (ev_valid),
        .o_tag   (ev_tag),
        .o_f     (ev_f)
    );

    trap_area #(
        .DW  (DW),
        .SW  (SW),
        .SHR (SHR)
    ) u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ASTART),
        .i_hmag  (r_hmag),
        .i_neg   (r_hneg),
        .i_sum   (r_sum),
        .o_done  (area_done),
        .o_area  (area_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (n_in == '0) ? S_OUT : S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (ev_valid && ev_tag.last) begin
                        r_state <= S_ASTART;
                    end
                end
                S_ASTART: begin
                    r_state <= S_AWAIT;
                end
                S_AWAIT: begin
                    if (area_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n     <= n_in;
            r_point <= a_ext <<< SC;
            r_hneg  <= diff[PW-1];
            r_res   <= '0;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_hmag <= quot;
            r_step <= r_hneg ? -signed'(PW'(quot)) : signed'(PW'(quot));
            // sign of h, not of b - a: a zero step is positive
            r_hneg <= r_hneg && (quot != '0);
            r_icnt <= '0;
            r_sum  <= '0;
        end
        if (issue) begin
            r_icnt  <= r_icnt + 1'b1;
            r_point <= r_point + r_step;
        end
        if ((r_state == S_EVAL) && ev_valid) begin
            r_sum <= r_sum + addend;
        end
        if ((r_state == S_AWAIT) && area_done) begin
            r_res <= area_val;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_area_out <= r_res;
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_out_valid;
    assign o_area  = r_area_out;

endmodule

// ----- verif/trapezoid_rule_integrator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_rule_integrator_test
// Self-checking bench: offers bound/count beats with random gaps, computes the
// expected trapezoid area bit-exactly in fixed point and compares every result
// beat in order, under random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module trapezoid_rule_integrator_test import trap_pkg::*;;

    localparam int unsigned COUNT_BITS = 20;
    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned PROD_SHIFT = 63 - FRAC_BITS;
    localparam logic [63:0] EVAL_MAG_MAX = (64'd128 << 16) - 1;
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic signed [BOUND_W-1:0] lower;
        logic signed [BOUND_W-1:0] upper;
        logic [CNT_IN_W-1:0]       count;
    } t_job;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [BOUND_W-1:0] i_lower_bound = '0;
    logic signed [BOUND_W-1:0] i_upper_bound = '0;
    logic [CNT_IN_W-1:0]       i_subintervals = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [AREA_W-1:0]  o_area;

    t_job                      pending_jobs[$];
    logic signed [AREA_W-1:0]  expected_areas[$];
    int                        send_gap = 0;
    int                        hold_left = 0;
    int                        results_seen = 0;
    int                        mismatches = 0;
    bit                        hold_done = 1'b0;

    trapezoid_rule_integrator #(
        .COUNT_BITS(COUNT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) uut (.*);

    always #5 i_clk = ~i_clk;

    // f(x) = sqrt((1 + x^2) / (1 + x^4)) in Q.30, x in Q.32
    function automatic logic [63:0] curve_q30(longint x);
        logic [63:0] mag, sq, sq_hi, quad, num, den, quo, rem, root, bit_w, root_in;
        mag = (x < 0) ? -x : x;
        mag = mag >> 16;
        if (mag > EVAL_MAG_MAX) mag = EVAL_MAG_MAX;
        sq = mag * mag;
        sq_hi = sq >> 16;
        quad = sq_hi * sq_hi;
        num = 64'h1_0000_0000 + sq;
        den = 64'h1_0000_0000 + quad;
        quo = num / den;
        rem = num % den;
        for (int k = 0; k < 30; k++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        root_in = quo << 30;
        root = 0;
        bit_w = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (root_in >= root + bit_w) begin
                root_in = root_in - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [AREA_W-1:0] predict_area(t_job job);
        longint      lo, hi, step, pt;
        logic [63:0] n, sum, mag_h, mag;
        logic [127:0] prod;
        logic [63:0] fv;
        n = 64'(job.count) & ((64'd1 << COUNT_BITS) - 1);
        if (n == 0) return '0;
        lo = longint'(job.lower);
        hi = longint'(job.upper);
        step = ((hi - lo) * 65536) / longint'(n);
        pt = lo * 65536;
        sum = curve_q30(pt);
        for (logic [63:0] i = 1; i <= n; i++) begin
            pt = pt + step;
            fv = curve_q30(pt);
            sum = sum + ((i == n) ? fv : (fv << 1));
        end
        mag_h = (step < 0) ? -step : step;
        prod = 128'(mag_h) * 128'(sum);
        if ((prod >> (64 + PROD_SHIFT)) != 0) mag = '1;
        else mag = 64'(prod >> PROD_SHIFT);
        if (step < 0) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return AREA_W'(64'h1_0000_0000 - mag);
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return AREA_W'(mag);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic t_job make_job(int lo, int hi, int cnt);
        t_job j;
        j.lower = BOUND_W'(lo);
        j.upper = BOUND_W'(hi);
        j.count = CNT_IN_W'(cnt);
        return j;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_areas.push_back(predict_area(
                    make_job(i_lower_bound, i_upper_bound, i_subintervals)));
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_jobs.size() > 0) begin
                    t_job j;
                    j = pending_jobs.pop_front();
                    i_lower_bound  <= j.lower;
                    i_upper_bound  <= j.upper;
                    i_subintervals <= j.count;
                    i_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                if (expected_areas.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected area beat: %0d", o_area);
                end else begin
                    logic signed [AREA_W-1:0] want;
                    want = expected_areas.pop_front();
                    if (o_area !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("area mismatch: expected %0d got %0d", want, o_area);
                    end
                end
            end
        end
    end

    // receiver stalls, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!hold_done && results_seen == 8) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_OFF_CYCLES;
                i_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < 25);
            end
        end
    end

    function automatic int rand_bound();
        return $urandom_range(32'hFFFFFF) - 32'h800000;
    endfunction

    initial begin
        int lo, hi, r;
        // directed: field extremes, reversed and empty intervals, zero count
        pending_jobs.push_back(make_job(0, 65536, 1));
        pending_jobs.push_back(make_job(-8388608, 8388607, 1));
        pending_jobs.push_back(make_job(8388607, -8388608, 1));
        pending_jobs.push_back(make_job(-8388608, 8388607, 64));
        pending_jobs.push_back(make_job(8388607, -8388608, 37));
        pending_jobs.push_back(make_job(-8388608, -8388608, 5));
        pending_jobs.push_back(make_job(8388607, 8388607, 3));
        pending_jobs.push_back(make_job(0, 0, 0));
        pending_jobs.push_back(make_job(-65536, 65536, 0));
        pending_jobs.push_back(make_job(-65536, 65536, 2));
        pending_jobs.push_back(make_job(65536, -65536, 2));
        pending_jobs.push_back(make_job(0, 1, 1));
        pending_jobs.push_back(make_job(-1, 0, 1));
        pending_jobs.push_back(make_job(-196608, 327680, 100));
        pending_jobs.push_back(make_job(-1, 1, 1048575));
        pending_jobs.push_back(make_job(0, 655360, 524288));
        for (int k = 0; k < 100; k++) begin
            r = $urandom_range(99);
            if (r < 60) begin
                lo = $urandom_range(32'h80000) - 32'h40000;
                hi = lo + $urandom_range(32'h60000) - 32'h20000;
            end else begin
                lo = rand_bound();
                hi = rand_bound();
            end
            r = $urandom_range(99);
            if (r < 75) r = $urandom_range(40, 1);
            else if (r < 95) r = $urandom_range(400, 41);
            else if (r < 98) r = 0;
            else r = $urandom_range(4000, 1000);
            pending_jobs.push_back(make_job(lo, hi, r));
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_jobs.size() == 0 && !i_valid);
        wait (expected_areas.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_areas.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #60ms;
        $display("status: fail");
        $finish;
    end

endmodule
